// File: rtl/mdke_pkg.sv
// Shared types, constants and digit helpers for the masked date key entry block.
package mdke_pkg;

  localparam int FIELD_LEN = 10;
  localparam int POS_W     = 4;
  localparam int CHAR_W    = 8;

  localparam logic [POS_W-1:0]  SEP_POS_A   = 4'd2;
  localparam logic [POS_W-1:0]  SEP_POS_B   = 4'd5;
  localparam logic [POS_W-1:0]  POS_END     = 4'd10;
  localparam logic [CHAR_W-1:0] KEY_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] SEP_RESET   = 8'd47;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_DATE = 1'b1;

  typedef logic [FIELD_LEN-1:0][CHAR_W-1:0] field_t;

  // One result beat before packing onto the stream
  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] echo;
    logic [6:0]        day;
    logic [6:0]        month;
    logic [13:0]       year;
    logic              last;
  } res_t;

  // Everything one keystroke does to the state and the output
  typedef struct packed {
    logic [1:0]        n_res;
    res_t              res0;
    res_t              res1;
    logic [POS_W-1:0]  cursor_nxt;
    logic              dig_we;
    logic [POS_W-1:0]  dig_idx;
    logic              sep_we;
    logic [POS_W-1:0]  sep_idx;
  } step_t;

  // Value of a stored character; anything but a digit counts as zero
  function automatic logic [3:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = c - ASCII_ZERO;
    if (c < ASCII_ZERO || c > ASCII_NINE) begin
      return 4'd0;
    end
    return d[3:0];
  endfunction

endpackage

// File: rtl/mdke_keystep.sv
// Keystroke decode: next cursor, buffer writes and up to two result beats.
module mdke_keystep (
  input  logic [7:0]      key,
  input  logic [3:0]      cursor,
  input  logic [7:0]      sep_char,
  input  mdke_pkg::field_t field,
  output mdke_pkg::step_t step
);
  import mdke_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  p1;
  logic [POS_W-1:0]  p2;
  logic              is_digit;
  logic              is_bs;
  logic              is_sp;
  logic              advance;
  logic [CHAR_W-1:0] last_char;
  logic [6:0]        day;
  logic [6:0]        month;
  logic [13:0]       year;
  res_t              echo_res;
  res_t              date_res;

  // A digit typed at the last position counts toward the completed date
  assign last_char = (is_digit && pos == (POS_END - 4'd1)) ? key : field[9];

  // Decode the date from the fixed digit positions
  assign day   = 7'(digit_of(field[0])) * 7'd10 + 7'(digit_of(field[1]));
  assign month = 7'(digit_of(field[3])) * 7'd10 + 7'(digit_of(field[4]));
  assign year  = 14'(digit_of(field[6])) * 14'd1000 + 14'(digit_of(field[7])) * 14'd100
               + 14'(digit_of(field[8])) * 14'd10 + 14'(digit_of(last_char));

  assign is_digit = (key >= ASCII_ZERO) && (key <= ASCII_NINE);
  assign is_bs    = (key == KEY_BS);
  assign is_sp    = (key == KEY_SPACE);
  assign pos      = (cursor >= POS_END) ? '0 : cursor;
  assign p1       = is_bs ? (pos - 4'd1) : (pos + 4'd1);
  assign p2       = p1 - 4'd1;
  assign advance  = is_digit || is_sp;

  always_comb begin
    echo_res      = '0;
    echo_res.kind = KIND_ECHO;
    date_res       = '0;
    date_res.kind  = KIND_DATE;
    date_res.day   = day;
    date_res.month = month;
    date_res.year  = year;

    step            = '0;
    step.cursor_nxt = pos;
    step.dig_idx    = pos;
    step.sep_idx    = p1;
    step.res0       = echo_res;
    step.res1       = echo_res;

    // First beat: the echo of the key, or of the stored character for a space
    if (is_digit) begin
      step.dig_we     = 1'b1;
      step.res0.echo  = key;
      step.n_res      = 2'd1;
      step.cursor_nxt = p1;
    end else if (is_sp) begin
      step.res0.echo  = field[pos];
      step.n_res      = 2'd1;
      step.cursor_nxt = p1;
    end else if (is_bs && pos != '0) begin
      step.res0.echo  = KEY_BS;
      step.n_res      = 2'd1;
      step.cursor_nxt = p1;
      // Step back over a separator with a second backspace
      if (p1 == SEP_POS_A || p1 == SEP_POS_B) begin
        step.res1.echo  = KEY_BS;
        step.n_res      = 2'd2;
        step.cursor_nxt = p2;
      end
    end

    // Second beat after an advance: separator insert or date complete
    if (advance) begin
      if (p1 == SEP_POS_A || p1 == SEP_POS_B) begin
        step.sep_we     = 1'b1;
        step.res1.echo  = sep_char;
        step.n_res      = 2'd2;
        step.cursor_nxt = p1 + 4'd1;
      end else if (p1 >= POS_END) begin
        step.res1       = date_res;
        step.n_res      = 2'd2;
        step.cursor_nxt = '0;
      end
    end

    step.res0.last = (step.n_res == 2'd1);
    step.res1.last = 1'b1;
  end

endmodule

// File: rtl/masked_date_key_entry.sv
// Top level of the masked dd/mm/yyyy key entry block: state, output buffer, ports.
//
// One keystroke beat goes in on the in_ stream and yields zero, one or two result
// beats on the out_ stream: character echoes (tuser 0) and, after the tenth
// position, a date-complete beat (tuser 1) carrying day, month and year. tlast
// marks the final beat of each keystroke. A keystroke is decoded in the cycle it
// is accepted and its results land in a two-beat output buffer; a new keystroke
// is taken whenever that buffer drains in the same cycle, so keys with one result
// (or none) run at one per cycle while out_tready holds; a two-result key holds
// off the next key until its first beat is taken, the buffer emitting one beat per
// cycle. The separator character is set by cfg_wr_en/cfg_wr_data (reset '/').
module masked_date_key_entry (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // separator_char
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] key_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // [7:0] echo_code, [14:8] day_value,
                                     // [21:15] month_value, [35:22] year_value,
                                     // [39:36] zero
  output logic [0:0]  out_tuser,     // [0] result_kind
  output logic        out_tlast      // last_of_run
);
  import mdke_pkg::*;

  logic [CHAR_W-1:0] sep_r;
  logic [POS_W-1:0]  cursor_r;
  logic [POS_W-1:0]  cursor_nxt;
  field_t            field_r;
  field_t            field_nxt;
  logic              v0_r;
  logic              v0_nxt;
  logic              v1_r;
  logic              v1_nxt;
  res_t              res0_r;
  res_t              res0_nxt;
  res_t              res1_r;
  res_t              res1_nxt;
  step_t             step;
  logic              in_fire;
  logic              out_fire;

  mdke_keystep u_keystep (
    .key      (in_tdata),
    .cursor   (cursor_r),
    .sep_char (sep_r),
    .field    (field_r),
    .step     (step)
  );

  assign out_fire  = out_tvalid && out_tready;
  assign in_tready = !v0_r || (out_tready && !v1_r);
  assign in_fire   = in_tvalid && in_tready;

  // Update cursor and stored characters on an accepted beat
  always_comb begin
    cursor_nxt = cursor_r;
    field_nxt  = field_r;
    if (in_fire) begin
      cursor_nxt = step.cursor_nxt;
      for (int i = 0; i < FIELD_LEN; i++) begin
        if (step.dig_we && step.dig_idx == POS_W'(i)) begin
          field_nxt[i] = in_tdata;
        end
        if (step.sep_we && step.sep_idx == POS_W'(i)) begin
          field_nxt[i] = sep_r;
        end
      end
    end
  end

  // Load the output buffer from a new key, or advance it on a taken beat
  always_comb begin
    v0_nxt   = v0_r;
    v1_nxt   = v1_r;
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    if (in_fire) begin
      v0_nxt   = (step.n_res != 2'd0);
      v1_nxt   = (step.n_res == 2'd2);
      res0_nxt = step.res0;
      res1_nxt = step.res1;
    end else if (out_fire) begin
      v0_nxt   = v1_r;
      v1_nxt   = 1'b0;
      res0_nxt = res1_r;
    end
  end

  // Control state and buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r    <= SEP_RESET;
      cursor_r <= '0;
      field_r  <= {FIELD_LEN{ASCII_ZERO}};
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sep_r <= cfg_wr_data;
      end
      cursor_r <= cursor_nxt;
      field_r  <= field_nxt;
      v0_r     <= v0_nxt;
      v1_r     <= v1_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

  assign out_tvalid = v0_r;
  assign out_tdata  = {4'b0, res0_r.year, res0_r.month, res0_r.day, res0_r.echo};
  assign out_tuser  = res0_r.kind;
  assign out_tlast  = res0_r.last;

endmodule
